// File: hw/rtl/csv_field_parser_defines.svh
// Assertion macros shared by the CSV field parser RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef CSV_FIELD_PARSER_DEFINES_SVH
`define CSV_FIELD_PARSER_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define CFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle
`define CFP_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

// File: hw/rtl/cfp_pkg.sv
// Shared types, constants and helpers for the CSV field parser.
// No dependencies; imported by cfp_cfg_if and by every module of the block.
package cfp_pkg;

	localparam int MAX_PENDING_SPACE = 16;
	localparam int SPACE_CNT_W = $clog2(MAX_PENDING_SPACE + 1);
	localparam int SPACE_IDX_W = (MAX_PENDING_SPACE > 1) ? $clog2(MAX_PENDING_SPACE) : 1;
	localparam logic [SPACE_CNT_W-1:0] SPACE_FULL = SPACE_CNT_W'(MAX_PENDING_SPACE);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE_CHAR = 2'd1;

	localparam logic [7:0] DELIMITER_RESET  = 8'd44;
	localparam logic [7:0] QUOTE_CHAR_RESET = 8'd34;

	typedef enum logic {
		CMD_BYTE,
		CMD_FIELD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [7:0]             data;
		logic [SPACE_CNT_W-1:0] spaces;
		logic                   line_end;
		logic                   truncated;
	} cmd_t;

	typedef struct packed {
		logic                   en;
		logic [SPACE_IDX_W-1:0] addr;
		logic [7:0]             data;
	} store_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_st_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

endpackage

// File: hw/rtl/cfp_cfg_if.sv
// Configuration write channel of the CSV field parser.
// Depends on cfp_pkg for the register index width.
interface cfp_cfg_if import cfp_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/cfp_in_if.sv
// Input byte channel of the CSV field parser.
// No dependencies.
interface cfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_line;

	modport source (output valid, output in_byte, output end_of_line, input ready);
	modport sink (input valid, input in_byte, input end_of_line, output ready);
endinterface

// File: hw/rtl/cfp_out_if.sv
// Result channel of the CSV field parser.
// No dependencies.
interface cfp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       field_end;
	logic       line_end;
	logic       field_truncated;
	logic       last_in_run;

	modport source (output valid, output out_byte, output has_byte, output field_end,
		output line_end, output field_truncated, output last_in_run, input ready);
	modport sink (input valid, input out_byte, input has_byte, input field_end,
		input line_end, input field_truncated, input last_in_run, output ready);
endinterface

// File: hw/rtl/csv_field_parser.sv
// Top level of the CSV field parser: front end, command queue, back end.
// Depends on cfp_pkg, the three channel interfaces and the cfp_* modules.
//
// Usage:
//   bytes  : one item per line byte, then one item with end_of_line set.
//   fields : results, one per content byte or field end; last_in_run marks
//            the final result caused by an input item.
//   cfg    : writes delimiter (index 0) and quote_char (index 1), always ready.
// Path: a result passes through the command queue and then the output
//   register. Items that produce no result (quote bytes, dropped or
//   buffered whitespace) never enter the queue.
// Throughput: one input item per cycle while the four-entry command queue
//   has room; the back end emits one result per cycle while fields.ready
//   is high, so an item that flushes n buffered spaces yields n+1 results.
//   A whitespace byte that must enter the 16-entry space buffer waits until
//   the queue has drained, as the back end reads that buffer during flushes.
// Reset: quote state, trim state, queue and output register clear; the
//   registers return to ',' and '"'. No clearing pass is needed.
// Stall: while fields.ready is low the output register holds; the queue
//   fills and then bytes.ready drops.
module csv_field_parser import cfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cfp_cfg_if.sink   cfg,
	cfp_in_if.sink    bytes,
	cfp_out_if.source fields
);

	logic      push;
	cmd_t      push_cmd;
	store_wr_t st_wr;
	queue_st_t q_st;
	logic      pop;
	logic      head_valid;
	cmd_t      head;

	cfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.items    (bytes),
		.q_st     (q_st),
		.push     (push),
		.push_cmd (push_cmd),
		.st_wr    (st_wr)
	);

	cfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.q_st       (q_st)
	);

	cfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.st_wr      (st_wr),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.fields     (fields)
	);

endmodule

// File: hw/rtl/cfp_front.sv
// Front end: configuration registers, quote tracking and whitespace trimming.
// Depends on cfp_pkg, cfp_cfg_if, cfp_in_if and csv_field_parser_defines.svh.
`include "csv_field_parser_defines.svh"

module cfp_front import cfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cfp_cfg_if.sink   cfg,
	cfp_in_if.sink    items,
	input  queue_st_t q_st,
	output logic      push,
	output cmd_t      push_cmd,
	output store_wr_t st_wr
);

	logic [7:0]             delimiter_q;
	logic [7:0]             quote_char_q;
	logic                   quoted_q, quoted_n;
	logic                   qpend_q, qpend_n;
	logic                   seen_q, seen_n;
	logic [SPACE_CNT_W-1:0] count_q, count_n;
	logic                   ovf_q, ovf_n;

	logic       fire;
	logic       fe_req;
	logic       cont;
	logic       quoted_eff;
	logic       push_req;
	logic       wr_req;
	logic [7:0] c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q  <= DELIMITER_RESET;
			quote_char_q <= QUOTE_CHAR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DELIMITER:  delimiter_q  <= cfg.data;
				REG_QUOTE_CHAR: quote_char_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		c          = items.in_byte;
		quoted_n   = quoted_q;
		qpend_n    = qpend_q;
		seen_n     = seen_q;
		count_n    = count_q;
		ovf_n      = ovf_q;
		fe_req     = 1'b0;
		cont       = 1'b0;
		quoted_eff = quoted_q & ~qpend_q;
		push_req   = 1'b0;
		wr_req     = 1'b0;
		push_cmd   = '{kind: CMD_BYTE, data: c, spaces: count_q, line_end: 1'b0,
			truncated: 1'b0};
		st_wr      = '{en: 1'b0, addr: count_q[SPACE_IDX_W-1:0], data: c};

		if (items.end_of_line) begin
			quoted_n = 1'b0;
			qpend_n  = 1'b0;
			fe_req   = 1'b1;
			push_cmd.line_end = 1'b1;
		end else if (qpend_q && c == quote_char_q) begin
			qpend_n = 1'b0;
			cont    = 1'b1;
		end else begin
			qpend_n  = 1'b0;
			quoted_n = quoted_eff;
			if (c == quote_char_q) begin
				if (quoted_eff)
					qpend_n = 1'b1;
				else
					quoted_n = 1'b1;
			end else if (c == delimiter_q && !quoted_eff) begin
				fe_req = 1'b1;
			end else begin
				cont = 1'b1;
			end
		end

		if (fe_req) begin
			push_req           = 1'b1;
			push_cmd.kind      = CMD_FIELD_END;
			push_cmd.data      = 8'd0;
			push_cmd.truncated = ovf_q;
			seen_n             = 1'b0;
			count_n            = '0;
			ovf_n              = 1'b0;
		end

		if (cont) begin
			if (is_ws(c)) begin
				if (seen_q) begin
					if (count_q < SPACE_FULL) begin
						wr_req  = 1'b1;
						count_n = count_q + SPACE_CNT_W'(1);
					end else begin
						ovf_n = 1'b1;
					end
				end
			end else begin
				push_req = 1'b1;
				count_n  = '0;
				seen_n   = 1'b1;
			end
		end

		// Hold buffer writes until the back end has drained every flush
		items.ready = !q_st.full && (q_st.empty || !wr_req);
		fire        = items.valid && items.ready;
		push        = push_req && fire;
		st_wr.en    = wr_req && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoted_q <= 1'b0;
			qpend_q  <= 1'b0;
			seen_q   <= 1'b0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
		end else if (fire) begin
			quoted_q <= quoted_n;
			qpend_q  <= qpend_n;
			seen_q   <= seen_n;
			count_q  <= count_n;
			ovf_q    <= ovf_n;
		end
	end

	`CFP_ASSERT(a_wr_queue_empty, !st_wr.en || q_st.empty, "space buffer written during a flush")
	`CFP_ASSERT(a_push_room, !push || !q_st.full, "command pushed into a full queue")
	`CFP_ASSERT(a_count_bound, count_q <= SPACE_FULL, "pending space count beyond buffer")

endmodule

// File: hw/rtl/cfp_queue.sv
// Short command queue between the front end and the back end.
// Depends on cfp_pkg and csv_field_parser_defines.svh.
`include "csv_field_parser_defines.svh"

module cfp_queue import cfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output logic      head_valid,
	output cmd_t      head,
	output queue_st_t q_st
);

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign q_st.full  = (count_q == QUEUE_FULL);
	assign q_st.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + QUEUE_CNT_W'(1);
				2'b01:   count_q <= count_q - QUEUE_CNT_W'(1);
				default: ;
			endcase
		end
	end

	`CFP_ASSERT(a_pop_nonempty, !pop || head_valid, "pop from an empty queue")

endmodule

// File: hw/rtl/cfp_back.sv
// Back end: pending-space store, flush sequencing and the output register.
// Depends on cfp_pkg, cfp_out_if and csv_field_parser_defines.svh.
`include "csv_field_parser_defines.svh"

module cfp_back import cfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  store_wr_t st_wr,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	cfp_out_if.source fields
);

	logic [7:0]             store_q [MAX_PENDING_SPACE];
	logic [SPACE_CNT_W-1:0] idx_q;
	logic                   valid_q;
	logic [7:0]             byte_q;
	logic                   hb_q, fe_q, le_q, tr_q, last_q;

	logic                   load;
	logic                   take;
	logic                   in_spaces;

	always_ff @(posedge clk) begin
		if (st_wr.en)
			store_q[st_wr.addr] <= st_wr.data;
	end

	assign load      = !valid_q || fields.ready;
	assign take      = load && head_valid;
	assign in_spaces = (head.kind == CMD_BYTE) && (idx_q != head.spaces);
	assign pop       = take && !in_spaces;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load)
				valid_q <= head_valid;
			if (take) begin
				if (in_spaces)
					idx_q <= idx_q + SPACE_CNT_W'(1);
				else
					idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (in_spaces) begin
				byte_q <= store_q[idx_q[SPACE_IDX_W-1:0]];
				hb_q   <= 1'b1;
				fe_q   <= 1'b0;
				le_q   <= 1'b0;
				tr_q   <= 1'b0;
				last_q <= 1'b0;
			end else if (head.kind == CMD_BYTE) begin
				byte_q <= head.data;
				hb_q   <= 1'b1;
				fe_q   <= 1'b0;
				le_q   <= 1'b0;
				tr_q   <= 1'b0;
				last_q <= 1'b1;
			end else begin
				byte_q <= 8'd0;
				hb_q   <= 1'b0;
				fe_q   <= 1'b1;
				le_q   <= head.line_end;
				tr_q   <= head.truncated;
				last_q <= 1'b1;
			end
		end
	end

	assign fields.valid           = valid_q;
	assign fields.out_byte        = byte_q;
	assign fields.has_byte        = hb_q;
	assign fields.field_end       = fe_q;
	assign fields.line_end        = le_q;
	assign fields.field_truncated = tr_q;
	assign fields.last_in_run     = last_q;

	`CFP_ASSERT(a_idx_bound, !(head_valid && head.kind == CMD_BYTE) || idx_q <= head.spaces,
		"flush index beyond pending count")
	`CFP_ASSERT(a_fe_no_byte, !(valid_q && fe_q) || !hb_q, "field end carries a byte")

endmodule
